### sv/shs_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// It has no dependencies. The top level sha256_stream_hash uses it.
package shs_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } req_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } rsp_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] v);
        return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] v);
        return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] v);
        return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] v);
        return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

### sv/sha256_stream_hash.sv
// SHA-256 over a byte stream, at most one byte per accepted word, digest as eight words.
// Depends on shs_pkg for the payload types, round constants and round functions.
// A byte that does not complete a block is absorbed in S_IDLE; a full block is
// compressed via S_R0, S_R1 and S_RND for rounds 0 to 15 and S_R0 to S_RND after,
// bound by the single read port of the schedule memory. Padding fills the rest of
// each block, then the digest is offered one word per cycle while rsp_stall is low.
// Reset restores the initial hash value and clears all control state; the schedule
// memory is not cleared, as every entry is written before it is read.
module sha256_stream_hash (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  shs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output shs_pkg::rsp_t rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_R0, S_R1, S_R2, S_R3, S_R4, S_RND,
        S_FOLD, S_PADGO, S_PAD, S_OUT
    } state_t;

    state_t      state_reg;
    logic [60:0] count_reg;
    logic [23:0] wacc_reg;
    logic [5:0]  t_reg;
    logic [31:0] acc_reg;
    logic [31:0] w_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] work_reg [8];
    logic        fin_reg;
    logic        pad_started_reg;
    logic        first_reg;
    logic        len_reg;
    logic        final_reg;
    logic [3:0]  widx_reg;
    logic [2:0]  oidx_reg;

    logic [31:0] mem [16];
    logic [31:0] rdata_reg;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;

    logic        accept;
    logic        out_accept;
    logic [31:0] pad_word;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sched_w;

    assign accept     = req_valid && !req_stall;
    assign out_accept = rsp_valid && !rsp_stall;
    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = (state_reg == S_OUT);
    assign rsp.digest_word = chain_reg[oidx_reg];
    assign rsp.word_index  = oidx_reg;
    assign rsp.last_word   = (oidx_reg == 3'd7);

    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    pad_word = 32'h80000000;
            2'd1:    pad_word = {wacc_reg[7:0], 24'h800000};
            2'd2:    pad_word = {wacc_reg[15:0], 16'h8000};
            default: pad_word = {wacc_reg[23:0], 8'h80};
        endcase
        sched_w = acc_reg + shs_pkg::small_s1(rdata_reg);
        t1 = work_reg[7] + shs_pkg::big_s1(work_reg[4])
            + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
            + shs_pkg::ROUND_K[t_reg] + w_reg;
        t2 = shs_pkg::big_s0(work_reg[0])
            + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]));

        mem_we    = 1'b0;
        mem_waddr = t_reg[3:0];
        mem_wdata = sched_w;
        mem_raddr = t_reg[3:0];
        unique case (state_reg)
            S_IDLE:
            begin
                mem_waddr = count_reg[5:2];
                mem_wdata = {wacc_reg, req.data_byte};
                mem_we    = accept && req.has_byte && (count_reg[1:0] == 2'd3);
            end
            S_R1:    mem_raddr = t_reg[3:0] + 4'd1;
            S_R2:    mem_raddr = t_reg[3:0] + 4'd9;
            S_R3:    mem_raddr = t_reg[3:0] + 4'd14;
            S_R4:    mem_we = 1'b1;
            S_PAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = widx_reg;
                if (first_reg)
                    mem_wdata = pad_word;
                else if (len_reg && widx_reg == 4'd14)
                    mem_wdata = count_reg[60:29];
                else if (len_reg && widx_reg == 4'd15)
                    mem_wdata = {count_reg[28:0], 3'b000};
                else
                    mem_wdata = 32'h0;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            wacc_reg        <= '0;
            t_reg           <= '0;
            acc_reg         <= '0;
            w_reg           <= '0;
            fin_reg         <= 1'b0;
            pad_started_reg <= 1'b0;
            first_reg       <= 1'b0;
            len_reg         <= 1'b0;
            final_reg       <= 1'b0;
            widx_reg        <= '0;
            oidx_reg        <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= shs_pkg::IV[i];
                work_reg[i]  <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        fin_reg <= req.last;
                        if (req.has_byte)
                        begin
                            wacc_reg  <= {wacc_reg[15:0], req.data_byte};
                            count_reg <= count_reg + 61'd1;
                        end
                        if (req.has_byte && count_reg[5:0] == 6'd63)
                            state_reg <= S_LOAD;
                        else if (req.last)
                            state_reg <= S_PADGO;
                    end
                end
                S_LOAD:
                begin
                    for (int i = 0; i < 8; i++)
                        work_reg[i] <= chain_reg[i];
                    t_reg     <= '0;
                    state_reg <= S_R0;
                end
                S_R0:    state_reg <= S_R1;
                S_R1:
                begin
                    if (t_reg[5:4] == 2'd0)
                    begin
                        w_reg     <= rdata_reg;
                        state_reg <= S_RND;
                    end
                    else
                    begin
                        acc_reg   <= rdata_reg;
                        state_reg <= S_R2;
                    end
                end
                S_R2:
                begin
                    acc_reg   <= acc_reg + shs_pkg::small_s0(rdata_reg);
                    state_reg <= S_R3;
                end
                S_R3:
                begin
                    acc_reg   <= acc_reg + rdata_reg;
                    state_reg <= S_R4;
                end
                S_R4:
                begin
                    w_reg     <= sched_w;
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    work_reg[7] <= work_reg[6];
                    work_reg[6] <= work_reg[5];
                    work_reg[5] <= work_reg[4];
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[3] <= work_reg[2];
                    work_reg[2] <= work_reg[1];
                    work_reg[1] <= work_reg[0];
                    work_reg[0] <= t1 + t2;
                    t_reg       <= t_reg + 6'd1;
                    state_reg   <= (t_reg == 6'd63) ? S_FOLD : S_R0;
                end
                S_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    if (final_reg)
                        state_reg <= S_OUT;
                    else if (fin_reg)
                        state_reg <= S_PADGO;
                    else
                        state_reg <= S_IDLE;
                end
                S_PADGO:
                begin
                    if (pad_started_reg)
                    begin
                        widx_reg  <= '0;
                        first_reg <= 1'b0;
                        len_reg   <= 1'b1;
                    end
                    else
                    begin
                        widx_reg        <= count_reg[5:2];
                        first_reg       <= 1'b1;
                        len_reg         <= (count_reg[5:3] != 3'd7);
                        pad_started_reg <= 1'b1;
                    end
                    state_reg <= S_PAD;
                end
                S_PAD:
                begin
                    first_reg <= 1'b0;
                    widx_reg  <= widx_reg + 4'd1;
                    if (widx_reg == 4'd15)
                    begin
                        final_reg <= len_reg;
                        state_reg <= S_LOAD;
                    end
                end
                S_OUT:
                begin
                    if (out_accept)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= shs_pkg::IV[i];
                            count_reg       <= '0;
                            fin_reg         <= 1'b0;
                            pad_started_reg <= 1'b0;
                            final_reg       <= 1'b0;
                            state_reg       <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
